[design/pfr_pkg.sv]
// shared constants, types and helpers for the plane frame pipeline
package pfr_pkg;

  // square root digit steps and the mask they leave on the root
  localparam int ROOT_ITERATIONS = 32;
  localparam int ROOT_BITS       = 32;
  localparam int ROOT_STEPS      = (ROOT_ITERATIONS < ROOT_BITS) ? ROOT_ITERATIONS : ROOT_BITS;
  localparam logic [ROOT_BITS-1:0] ROOT_MASK =
    ~((ROOT_BITS'(1) << (ROOT_BITS - ROOT_STEPS)) - ROOT_BITS'(1));

  // quotient bits of the normalizing divide and unit length in Q1.30
  localparam int QUO_BITS = 31;
  localparam logic [QUO_BITS-1:0] UNIT_ONE = QUO_BITS'(32'h4000_0000);

  // stages inside one unit-vector pipe
  localparam int UNIT_LAT = 5 + ROOT_BITS + QUO_BITS;

  // three block-scaled components, each signed 31 bits
  typedef logic [2:0][30:0] svec_t;
  // three unit components, each signed Q1.30 in 32 bits
  typedef logic [2:0][31:0] uvec_t;

  // bit length of a magnitude of up to 65 bits
  function automatic logic [6:0] bit_len(input logic [64:0] v);
    logic [6:0] n;
    n = 7'd0;
    for (int i = 0; i < 65; i++) begin
      if (v[i]) n = 7'(i + 1);
    end
    return n;
  endfunction

  // shift a magnitude so the block maximum lands in [2^29, 2^30), then sign it
  function automatic logic [30:0] scale_c(input logic [64:0] mag, input logic neg,
                                          input logic [6:0] len);
    logic [64:0] m;
    logic [30:0] s;
    if (len == 7'd0) begin
      m = '0;
    end else if (len > 7'd30) begin
      m = mag >> (len - 7'd30);
    end else begin
      m = mag << (7'd30 - len);
    end
    s = {1'b0, m[29:0]};
    return neg ? 31'(-s) : s;
  endfunction

endpackage

[design/pfr_unit.sv]
// unit vector pipe: sum of squares, bit-per-stage root, bit-per-stage divide
module pfr_unit import pfr_pkg::*; (
  input  logic  clk_i,
  input  logic  en_i,
  input  svec_t c_i,
  output uvec_t u_o,
  output logic  zero_o
);

  // magnitudes and squares
  logic [29:0] cmag [3];
  logic [29:0] m1_q [3];
  logic        n1_q [3];
  logic [59:0] sq_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cmag[i] = c_i[i][30] ? 30'(-c_i[i]) : c_i[i][29:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        m1_q[i] <= cmag[i];
        n1_q[i] <= c_i[i][30];
        sq_q[i] <= cmag[i] * cmag[i];
      end
    end
  end

  // root pipeline, stage zero holds the sum of squares
  logic [61:0]          rem_q [ROOT_BITS+1];
  logic [ROOT_BITS-1:0] res_q [ROOT_BITS+1];
  logic [29:0]          rm_q  [ROOT_BITS+1][3];
  logic                 rn_q  [ROOT_BITS+1][3];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= 62'(sq_q[0]) + 62'(sq_q[1]) + 62'(sq_q[2]);
      res_q[0] <= '0;
      for (int i = 0; i < 3; i++) begin
        rm_q[0][i] <= m1_q[i];
        rn_q[0][i] <= n1_q[i];
      end
    end
  end

  for (genvar k = 0; k < ROOT_BITS; k++) begin : g_root
    localparam int J = ROOT_BITS - 1 - k;
    logic [65:0] trial;
    logic        take;

    // one root bit: keep it when the trial square still fits
    assign trial = ({34'd0, res_q[k]} << (J + 1)) | (66'd1 << (2 * J));
    assign take  = ({4'd0, rem_q[k]} >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1] <= take ? (rem_q[k] - trial[61:0]) : rem_q[k];
        res_q[k+1] <= take ? (res_q[k] | (ROOT_BITS'(1) << J)) : res_q[k];
        for (int i = 0; i < 3; i++) begin
          rm_q[k+1][i] <= rm_q[k][i];
          rn_q[k+1][i] <= rn_q[k][i];
        end
      end
    end
  end

  // numerators and divisor for rounded divide
  logic [ROOT_BITS-1:0] root;
  logic [61:0]          num_q [3];
  logic [32:0]          den_q;
  logic                 pz_q;
  logic                 pn_q [3];

  assign root = res_q[ROOT_BITS] & ROOT_MASK;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        num_q[i] <= {1'b0, rm_q[ROOT_BITS][i], 31'd0} + {30'd0, root};
        pn_q[i]  <= rn_q[ROOT_BITS][i];
      end
      den_q <= {root, 1'b0};
      pz_q  <= (root == '0);
    end
  end

  // divide pipeline, stage zero holds the saturation test and top bits
  logic [32:0]         drem_q [QUO_BITS+1][3];
  logic [QUO_BITS-1:0] dq_q   [QUO_BITS+1][3];
  logic [30:0]         dnl_q  [QUO_BITS+1][3];
  logic                dsat_q [QUO_BITS+1][3];
  logic                dn_q   [QUO_BITS+1][3];
  logic [32:0]         dden_q [QUO_BITS+1];
  logic                dz_q   [QUO_BITS+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        dsat_q[0][i] <= ({2'd0, num_q[i]} >= {den_q, 31'd0});
        drem_q[0][i] <= {2'd0, num_q[i][61:31]};
        dnl_q[0][i]  <= num_q[i][30:0];
        dq_q[0][i]   <= '0;
        dn_q[0][i]   <= pn_q[i];
      end
      dden_q[0] <= den_q;
      dz_q[0]   <= pz_q;
    end
  end

  for (genvar k = 0; k < QUO_BITS; k++) begin : g_div
    localparam int B = QUO_BITS - 1 - k;
    logic [33:0] part [3];
    logic        fit  [3];

    // one quotient bit per component
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        part[i] = {drem_q[k][i], dnl_q[k][i][B]};
        fit[i]  = (part[i] >= {1'b0, dden_q[k]});
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int i = 0; i < 3; i++) begin
          drem_q[k+1][i] <= fit[i] ? 33'(part[i] - {1'b0, dden_q[k]}) : part[i][32:0];
          dq_q[k+1][i]   <= fit[i] ? (dq_q[k][i] | (QUO_BITS'(1) << B)) : dq_q[k][i];
          dnl_q[k+1][i]  <= dnl_q[k][i];
          dsat_q[k+1][i] <= dsat_q[k][i];
          dn_q[k+1][i]   <= dn_q[k][i];
        end
        dden_q[k+1] <= dden_q[k];
        dz_q[k+1]   <= dz_q[k];
      end
    end
  end

  // saturate to one and restore the sign
  logic [QUO_BITS-1:0] qsat [3];
  uvec_t               u_q;
  logic                z_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dsat_q[QUO_BITS][i] || (dq_q[QUO_BITS][i] > UNIT_ONE)) begin
        qsat[i] = UNIT_ONE;
      end else begin
        qsat[i] = dq_q[QUO_BITS][i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        u_q[i] <= dn_q[QUO_BITS][i] ? 32'(-{1'b0, qsat[i]}) : {1'b0, qsat[i]};
      end
      z_q <= dz_q[QUO_BITS];
    end
  end

  assign u_o    = u_q;
  assign zero_o = z_q;

endmodule

[design/plane_frame_from_three_points.sv]
// each accepted word becomes one result word at the outputs, in the order accepted
// throughput: one word per cycle unless the output stalls; each normalization runs a 32-stage root and
//   a 31-stage divide, one bit per stage, and three such pipes work side by side
// a stall at the output while a result word is valid freezes every stage; nothing is dropped or repeated
// reset clears only the stage valid bits; data registers are not reset
module plane_frame_from_three_points import pfr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [31:0] p0_x_i,
  input  logic [31:0] p0_y_i,
  input  logic [31:0] p0_z_i,
  input  logic [31:0] p1_x_i,
  input  logic [31:0] p1_y_i,
  input  logic [31:0] p1_z_i,
  input  logic [31:0] p2_x_i,
  input  logic [31:0] p2_y_i,
  input  logic [31:0] p2_z_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [31:0] ex_x_o,
  output logic [31:0] ex_y_o,
  output logic [31:0] ex_z_o,
  output logic [31:0] ey_x_o,
  output logic [31:0] ey_y_o,
  output logic [31:0] ey_z_o,
  output logic [31:0] ez_x_o,
  output logic [31:0] ez_y_o,
  output logic [31:0] ez_z_o,
  output logic        degenerate_o
);

  localparam int FrontLat = 11;
  localparam int Lat      = FrontLat + UNIT_LAT + 1;

  // stage valid bits and global advance
  logic [Lat-1:0] vld_q;
  logic           adv;

  assign adv     = !(vld_q[Lat-1] && stall_i);
  assign stall_o = !adv;
  assign valid_o = vld_q[Lat-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Lat-2:0], valid_i};
    end
  end

  // edge vectors
  logic [31:0] p0 [3];
  logic [31:0] p1 [3];
  logic [31:0] p2 [3];
  logic signed [32:0] a_q [3];
  logic signed [32:0] b_q [3];

  assign p0 = '{p0_x_i, p0_y_i, p0_z_i};
  assign p1 = '{p1_x_i, p1_y_i, p1_z_i};
  assign p2 = '{p2_x_i, p2_y_i, p2_z_i};

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        a_q[i] <= $signed({p1[i][31], p1[i]}) - $signed({p0[i][31], p0[i]});
        b_q[i] <= $signed({p2[i][31], p2[i]}) - $signed({p0[i][31], p0[i]});
      end
    end
  end

  // cross product partial products
  logic signed [65:0] pp_q [3];
  logic signed [65:0] pq_q [3];
  logic signed [32:0] a2_q [3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pp_q[0] <= a_q[1] * b_q[2];
      pq_q[0] <= a_q[2] * b_q[1];
      pp_q[1] <= a_q[2] * b_q[0];
      pq_q[1] <= a_q[0] * b_q[2];
      pp_q[2] <= a_q[0] * b_q[1];
      pq_q[2] <= a_q[1] * b_q[0];
      a2_q    <= a_q;
    end
  end

  // exact normal
  logic signed [66:0] n_q  [3];
  logic signed [32:0] a3_q [3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        n_q[i] <= {pp_q[i][65], pp_q[i]} - {pq_q[i][65], pq_q[i]};
      end
      a3_q <= a2_q;
    end
  end

  // magnitudes and signs
  logic [64:0] nmag_q [3];
  logic        nneg_q [3];
  logic [31:0] amag_q [3];
  logic        aneg_q [3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        nmag_q[i] <= n_q[i][66] ? 65'(-n_q[i]) : 65'(n_q[i]);
        nneg_q[i] <= n_q[i][66];
        amag_q[i] <= a3_q[i][32] ? 32'(-a3_q[i]) : 32'(a3_q[i]);
        aneg_q[i] <= a3_q[i][32];
      end
    end
  end

  // block lengths
  logic [6:0]  nlen_q;
  logic [6:0]  alen_q;
  logic [64:0] nmag5_q [3];
  logic        nneg5_q [3];
  logic [31:0] amag5_q [3];
  logic        aneg5_q [3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      nlen_q  <= bit_len(nmag_q[0] | nmag_q[1] | nmag_q[2]);
      alen_q  <= bit_len({33'd0, amag_q[0] | amag_q[1] | amag_q[2]});
      nmag5_q <= nmag_q;
      nneg5_q <= nneg_q;
      amag5_q <= amag_q;
      aneg5_q <= aneg_q;
    end
  end

  // block scaling of normal and first edge
  svec_t sn_q;
  svec_t sa_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        sn_q[i] <= scale_c(nmag5_q[i], nneg5_q[i], nlen_q);
        sa_q[i] <= scale_c({33'd0, amag5_q[i]}, aneg5_q[i], alen_q);
      end
    end
  end

  // carry scaled normal and edge until the in-plane axis is ready
  svec_t sn_dly_q [5];
  svec_t sa_dly_q [5];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sn_dly_q[0] <= sn_q;
      sa_dly_q[0] <= sa_q;
      for (int k = 1; k < 5; k++) begin
        sn_dly_q[k] <= sn_dly_q[k-1];
        sa_dly_q[k] <= sa_dly_q[k-1];
      end
    end
  end

  // in-plane axis partial products: normal cross edge
  logic signed [61:0] tp_q [3];
  logic signed [61:0] tq_q [3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      tp_q[0] <= $signed(sn_q[1]) * $signed(sa_q[2]);
      tq_q[0] <= $signed(sn_q[2]) * $signed(sa_q[1]);
      tp_q[1] <= $signed(sn_q[2]) * $signed(sa_q[0]);
      tq_q[1] <= $signed(sn_q[0]) * $signed(sa_q[2]);
      tp_q[2] <= $signed(sn_q[0]) * $signed(sa_q[1]);
      tq_q[2] <= $signed(sn_q[1]) * $signed(sa_q[0]);
    end
  end

  // in-plane axis difference
  logic signed [62:0] t_q [3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        t_q[i] <= {tp_q[i][61], tp_q[i]} - {tq_q[i][61], tq_q[i]};
      end
    end
  end

  // in-plane axis magnitudes
  logic [61:0] tmag_q [3];
  logic        tneg_q [3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        tmag_q[i] <= t_q[i][62] ? 62'(-t_q[i]) : 62'(t_q[i]);
        tneg_q[i] <= t_q[i][62];
      end
    end
  end

  // in-plane axis block length
  logic [6:0]  tlen_q;
  logic [61:0] tmag10_q [3];
  logic        tneg10_q [3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      tlen_q   <= bit_len({3'd0, tmag_q[0] | tmag_q[1] | tmag_q[2]});
      tmag10_q <= tmag_q;
      tneg10_q <= tneg_q;
    end
  end

  // in-plane axis scaling
  svec_t sy_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        sy_q[i] <= scale_c({3'd0, tmag10_q[i]}, tneg10_q[i], tlen_q);
      end
    end
  end

  // three unit-vector pipes
  uvec_t ux;
  uvec_t uy;
  uvec_t uz;
  logic  zx;
  logic  zy;
  logic  zz;

  pfr_unit u_unit_x (.clk_i(clk_i), .en_i(adv), .c_i(sa_dly_q[4]), .u_o(ux), .zero_o(zx));
  pfr_unit u_unit_y (.clk_i(clk_i), .en_i(adv), .c_i(sy_q),        .u_o(uy), .zero_o(zy));
  pfr_unit u_unit_z (.clk_i(clk_i), .en_i(adv), .c_i(sn_dly_q[4]), .u_o(uz), .zero_o(zz));

  // output word with degenerate blanking
  uvec_t ex_q;
  uvec_t ey_q;
  uvec_t ez_q;
  logic  deg_q;
  logic  deg;

  assign deg = zx || zy || zz;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ex_q  <= deg ? '0 : ux;
      ey_q  <= deg ? '0 : uy;
      ez_q  <= deg ? '0 : uz;
      deg_q <= deg;
    end
  end

  assign ex_x_o       = ex_q[0];
  assign ex_y_o       = ex_q[1];
  assign ex_z_o       = ex_q[2];
  assign ey_x_o       = ey_q[0];
  assign ey_y_o       = ey_q[1];
  assign ey_z_o       = ey_q[2];
  assign ez_x_o       = ez_q[0];
  assign ez_y_o       = ez_q[1];
  assign ez_z_o       = ez_q[2];
  assign degenerate_o = deg_q;

  // degenerate words carry all-zero axes
  a_deg_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && degenerate_o) |-> ((ex_q == '0) && (ey_q == '0) && (ez_q == '0)))
    else $error("degenerate word with nonzero axes");

  // a regular frame has a nonzero x axis
  a_ex_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !degenerate_o) |-> (ex_q != '0))
    else $error("regular frame with zero x axis");

  // the ez x and ey y unit components stay within plus and minus one
  a_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (($signed(ez_x_o) <= 32'sh4000_0000) && ($signed(ez_x_o) >= -32'sh4000_0000)
              && ($signed(ey_y_o) <= 32'sh4000_0000) && ($signed(ey_y_o) >= -32'sh4000_0000)))
    else $error("unit component out of range");

  // a frozen pipeline keeps its valid bits
  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> (vld_q == $past(vld_q)))
    else $error("stage valid bits moved during a stall");

endmodule

[dv/testbench.sv]
// self-checking testbench for the three-point plane frame pipeline
`timescale 1ns / 1ps

module testbench;

  // per-component magnitude with sign for wide cross terms
  typedef struct {
    logic [64:0] mag;
    logic        neg;
  } wide_t;

  typedef struct {
    logic [31:0] ax [9];
    logic        degen;
  } frame_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        valid_i = 1'b0;
  logic        stall_o;
  logic [31:0] pt_i [9];
  logic        valid_o;
  logic        stall_i = 1'b0;
  logic [31:0] ax_o [9];
  logic        degenerate_o;

  int sender_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles = 0;
  int n_errors = 0;
  frame_t frame_q [$];

  initial for (int i = 0; i < 9; i++) pt_i[i] = '0;

  always #10 clk_i = ~clk_i;

  plane_frame_from_three_points dut (
    .clk_i, .rst_ni, .valid_i, .stall_o,
    .p0_x_i(pt_i[0]), .p0_y_i(pt_i[1]), .p0_z_i(pt_i[2]),
    .p1_x_i(pt_i[3]), .p1_y_i(pt_i[4]), .p1_z_i(pt_i[5]),
    .p2_x_i(pt_i[6]), .p2_y_i(pt_i[7]), .p2_z_i(pt_i[8]),
    .valid_o, .stall_i,
    .ex_x_o(ax_o[0]), .ex_y_o(ax_o[1]), .ex_z_o(ax_o[2]),
    .ey_x_o(ax_o[3]), .ey_y_o(ax_o[4]), .ey_z_o(ax_o[5]),
    .ez_x_o(ax_o[6]), .ez_y_o(ax_o[7]), .ez_z_o(ax_o[8]),
    .degenerate_o
  );

  // exact a*b - c*d on 33-bit signed operands
  function automatic wide_t cross_term(longint a, longint b, longint c, longint d);
    logic signed [67:0] r;
    wide_t w;
    r = 68'(a) * 68'(b) - 68'(c) * 68'(d);
    w.neg = r < 0;
    w.mag = 65'(w.neg ? -r : r);
    return w;
  endfunction

  // common power-of-two shift so the largest magnitude lands in [2^29, 2^30)
  function automatic void norm_shift(input wide_t w [3], output longint o [3]);
    int len;
    logic [64:0] m;
    len = 0;
    for (int i = 0; i < 3; i++)
      for (int b = 0; b < 65; b++) if (w[i].mag[b] && b + 1 > len) len = b + 1;
    for (int i = 0; i < 3; i++) begin
      if (len == 0) m = '0;
      else if (len > 30) m = w[i].mag >> (len - 30);
      else m = w[i].mag << (30 - len);
      o[i] = w[i].neg ? -longint'(m) : longint'(m);
    end
  endfunction

  // unit vector in Q1.30; returns 0 on a zero norm
  function automatic bit unit_of(input longint c [3], output longint u [3]);
    logic [63:0] s, r, cand, q, mg;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      mg = c[i] < 0 ? -c[i] : c[i];
      s += mg * mg;
    end
    if (s == 0) return 0;
    r = 0;
    for (int i = 0; i < 32; i++) begin
      cand = r | (64'd1 << (31 - i));
      if (cand * cand <= s) r = cand;
    end
    if (r == 0) return 0;
    for (int i = 0; i < 3; i++) begin
      mg = c[i] < 0 ? -c[i] : c[i];
      q = ((mg << 31) + r) / (r << 1);
      if (q > 64'h4000_0000) q = 64'h4000_0000;
      u[i] = c[i] < 0 ? -longint'(q) : longint'(q);
    end
    return 1;
  endfunction

  function automatic frame_t predict_frame(logic [31:0] p [9]);
    longint a [3], b [3], sa [3], sn [3], sy [3], ux [3], uy [3], uz [3];
    wide_t n [3], y [3], av [3];
    longint t;
    bit ok;
    frame_t f;
    for (int i = 0; i < 3; i++) begin
      a[i] = longint'($signed(p[3+i])) - longint'($signed(p[i]));
      b[i] = longint'($signed(p[6+i])) - longint'($signed(p[i]));
    end
    n[0] = cross_term(a[1], b[2], a[2], b[1]);
    n[1] = cross_term(a[2], b[0], a[0], b[2]);
    n[2] = cross_term(a[0], b[1], a[1], b[0]);
    norm_shift(n, sn);
    for (int i = 0; i < 3; i++) begin
      av[i].neg = a[i] < 0;
      av[i].mag = 65'(a[i] < 0 ? -a[i] : a[i]);
    end
    norm_shift(av, sa);
    for (int i = 0; i < 3; i++) begin
      t = sn[(i+1)%3] * sa[(i+2)%3] - sn[(i+2)%3] * sa[(i+1)%3];
      y[i].neg = t < 0;
      y[i].mag = 65'(t < 0 ? -t : t);
    end
    norm_shift(y, sy);
    ok = unit_of(sa, ux);
    if (ok) ok = unit_of(sy, uy);
    if (ok) ok = unit_of(sn, uz);
    for (int i = 0; i < 3; i++) begin
      f.ax[i]   = ok ? ux[i][31:0] : '0;
      f.ax[3+i] = ok ? uy[i][31:0] : '0;
      f.ax[6+i] = ok ? uz[i][31:0] : '0;
    end
    f.degen = !ok;
    return f;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    n_errors++;
  endtask

  // offer one word and hold it until accepted
  task automatic send_points(logic [31:0] p [9]);
    while ($urandom_range(99) < sender_idle_pct) begin
      valid_i <= 1'b0;
      @(posedge clk_i);
    end
    valid_i <= 1'b1;
    for (int i = 0; i < 9; i++) pt_i[i] <= p[i];
    frame_q.push_back(predict_frame(p));
    @(posedge clk_i);
    while (stall_o) @(posedge clk_i);
  endtask

  task automatic go_idle();
    valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // receiver stall pattern, with a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      stall_i <= 1'b1;
    end else begin
      stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // compare each accepted result word with the oldest prediction
  always @(posedge clk_i) begin
    frame_t w;
    if (rst_ni && valid_o && !stall_i) begin
      if (frame_q.size() == 0) begin
        $display("unexpected result word");
        n_errors++;
      end else begin
        w = frame_q.pop_front();
        for (int i = 0; i < 9; i++)
          if (ax_o[i] !== w.ax[i]) report_mismatch($sformatf("axis %0d", i), ax_o[i], w.ax[i]);
        if (degenerate_o !== w.degen)
          report_mismatch("degenerate", 32'(degenerate_o), 32'(w.degen));
      end
    end
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(2000)) - 1000) <<< 16;
      2: return 32'($signed($urandom_range(200000)) - 100000);
      default: return {$urandom_range(1) ? 16'hffff : 16'h0, 16'($urandom())};
    endcase
  endfunction

  task automatic test_directed();
    logic [31:0] p [9];
    logic [31:0] ext [4] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff};
    // all points coincide
    p = '{default: 32'h0}; send_points(p);
    // axis-aligned unit triangle
    p = '{0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000, 0}; send_points(p);
    // p1 equals p0: zero edge
    p = '{5, 6, 7, 5, 6, 7, 1, 2, 3}; send_points(p);
    // collinear points
    p = '{0, 0, 0, 1, 2, 3, 2, 4, 6}; send_points(p);
    // extreme corners, widest edges
    p = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
          32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000};
    send_points(p);
    p = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
          32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff};
    send_points(p);
    // tiny edges, scaled up exactly
    p = '{0, 0, 0, 1, 0, 0, 0, 0, 32'hffff_ffff}; send_points(p);
    for (int k = 0; k < 14; k++) begin
      for (int i = 0; i < 9; i++) p[i] = ext[$urandom_range(3)];
      send_points(p);
    end
    go_idle();
  endtask

  task automatic test_random(int count);
    logic [31:0] p [9];
    int s;
    for (int k = 0; k < count; k++) begin
      for (int i = 0; i < 9; i++) p[i] = rand_coord();
      s = $urandom_range(9);
      // some collinear or coincident triples
      if (s == 0) for (int i = 0; i < 3; i++) p[6+i] = p[3+i];
      else if (s == 1) for (int i = 0; i < 3; i++) p[6+i] = p[i] + 2 * (p[3+i] - p[i]);
      send_points(p);
    end
    go_idle();
  endtask

  task automatic test_backpressure();
    logic [31:0] p [9];
    sender_idle_pct = 0;
    recv_idle_pct = 0;
    hold_cycles = 300;
    for (int k = 0; k < 150; k++) begin
      for (int i = 0; i < 9; i++) p[i] = rand_coord();
      send_points(p);
    end
    go_idle();
  endtask

  task automatic drain_results();
    while (frame_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    sender_idle_pct = 21; recv_idle_pct = 65;
    test_directed();
    test_random(250);
    sender_idle_pct = 65; recv_idle_pct = 21;
    test_random(250);
    sender_idle_pct = 0; recv_idle_pct = 0;
    test_random(100);
    test_backpressure();
    drain_results();
    if (n_errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  initial begin
    #2ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule

[plane_frame_from_three_points.f]
design/pfr_pkg.sv
design/pfr_unit.sv
design/plane_frame_from_three_points.sv
dv/testbench.sv
